// ===== rtl/core/llf_pkg.sv =====
// package for the link loss failsafe: codes, register defaults, item types
// no dependencies; imported by every module of the block
`default_nettype none

package llf_pkg;

  localparam int unsigned TimeW   = 32;
  localparam int unsigned HoldW   = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 32;

  // op codes of an input item
  localparam logic OpUpdate = 1'b0;
  localparam logic OpReset  = 1'b1;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgLossTimeout = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgRecovery    = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgWarningHold = 2'd2;

  // register defaults after reset
  localparam logic [TimeW-1:0] LossTimeoutRst = 32'd1000;
  localparam logic [TimeW-1:0] RecoveryRst    = 32'd500;
  localparam logic [HoldW-1:0] WarningHoldRst = 16'd100;

  // silence reported when no frame was ever seen
  localparam logic [TimeW-1:0] SilenceNever = {TimeW{1'b1}};

  typedef enum logic [1:0] {
    MODE_OK         = 2'd0,
    MODE_WARNING    = 2'd1,
    MODE_ACTIVE     = 2'd2,
    MODE_RECOVERING = 2'd3
  } mode_e;

  typedef struct packed {
    logic [TimeW-1:0] loss_timeout_ms;
    logic [TimeW-1:0] recovery_ms;
    logic [HoldW-1:0] warning_hold_ms;
  } cfg_t;

  typedef struct packed {
    logic             op;
    logic [TimeW-1:0] now_ms;
    logic             frame_seen;
  } item_t;

endpackage

`default_nettype wire

// ===== rtl/core/llf_cfg.sv =====
// configuration register file of the link loss failsafe
// depends on llf_pkg
`default_nettype none

module llf_cfg (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        wr_en_i,
  input  wire logic [llf_pkg::CfgIdxW-1:0] wr_index_i,
  input  wire logic [llf_pkg::CfgW-1:0]    wr_data_i,
  output llf_pkg::cfg_t                    cfg_o
);
  import llf_pkg::*;

  cfg_t cfg_q, cfg_d;

  // decode the write, unknown indexes leave everything alone
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (wr_index_i)
        CfgLossTimeout: cfg_d.loss_timeout_ms = wr_data_i;
        CfgRecovery:    cfg_d.recovery_ms     = wr_data_i;
        CfgWarningHold: cfg_d.warning_hold_ms = wr_data_i[HoldW-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.loss_timeout_ms <= LossTimeoutRst;
      cfg_q.recovery_ms     <= RecoveryRst;
      cfg_q.warning_hold_ms <= WarningHoldRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/core/llf_core.sv =====
// failsafe state machine: link state, frame timestamps and disarm flag
// depends on llf_pkg; updated once per item when en_i is high
`default_nettype none

module llf_core (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           en_i,
  input  wire llf_pkg::item_t item_i,
  input  wire llf_pkg::cfg_t  cfg_i,
  output llf_pkg::mode_e      link_state_o,
  output logic                disarm_o
);
  import llf_pkg::*;

  mode_e            mode_q, mode_d;
  logic [TimeW-1:0] last_frame_q, last_frame_d;
  logic [TimeW-1:0] lost_q, lost_d;
  logic [TimeW-1:0] regained_q, regained_d;
  logic             disarmed_q, disarmed_d;

  logic [TimeW-1:0] last_eff;
  logic [TimeW-1:0] silence;
  logic             is_reset;
  logic             frame;
  logic             loss_hit;
  logic             hold_over;
  logic             recov_done;

  // silence since the last frame, all ones when nothing was ever received
  assign is_reset   = (item_i.op == OpReset);
  assign frame      = item_i.frame_seen;
  assign last_eff   = frame ? item_i.now_ms : last_frame_q;
  assign silence    = (last_eff == '0) ? SilenceNever : (item_i.now_ms - last_eff);
  assign loss_hit   = (silence >= cfg_i.loss_timeout_ms);
  assign hold_over  = ((item_i.now_ms - lost_q) > {{(TimeW-HoldW){1'b0}}, cfg_i.warning_hold_ms});
  assign recov_done = ((item_i.now_ms - regained_q) >= cfg_i.recovery_ms);

  // next state
  always_comb begin
    mode_d = mode_q;
    if (is_reset) begin
      mode_d = MODE_OK;
    end else begin
      case (mode_q)
        MODE_OK: begin
          if (loss_hit) mode_d = MODE_WARNING;
        end
        MODE_WARNING: begin
          if (frame) mode_d = MODE_OK;
          else if (hold_over) mode_d = MODE_ACTIVE;
        end
        MODE_ACTIVE: begin
          if (frame) mode_d = MODE_RECOVERING;
        end
        MODE_RECOVERING: begin
          if (!frame) mode_d = MODE_ACTIVE;
          else if (recov_done) mode_d = MODE_OK;
        end
        default: mode_d = MODE_OK;
      endcase
    end
  end

  // timestamps and disarm flag that go with each transition
  always_comb begin
    last_frame_d = last_eff;
    lost_d       = lost_q;
    regained_d   = regained_q;
    disarmed_d   = disarmed_q;
    if (is_reset) begin
      last_frame_d = item_i.now_ms;
      lost_d       = '0;
      regained_d   = '0;
      disarmed_d   = 1'b0;
    end else begin
      case (mode_q)
        MODE_OK: begin
          if (loss_hit) lost_d = item_i.now_ms;
        end
        MODE_WARNING: begin
          if (!frame && hold_over) disarmed_d = 1'b1;
        end
        MODE_ACTIVE: begin
          if (frame) regained_d = item_i.now_ms;
        end
        MODE_RECOVERING: begin
          if (frame && recov_done) disarmed_d = 1'b0;
        end
        default: disarmed_d = disarmed_q;
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_OK;
      last_frame_q <= '0;
      lost_q       <= '0;
      regained_q   <= '0;
      disarmed_q   <= 1'b0;
    end else if (en_i) begin
      mode_q       <= mode_d;
      last_frame_q <= last_frame_d;
      lost_q       <= lost_d;
      regained_q   <= regained_d;
      disarmed_q   <= disarmed_d;
    end
  end

  // result of this item is the state after it
  assign link_state_o = mode_d;
  assign disarm_o     = disarmed_d;

`ifndef SYNTHESIS
  // disarm follows the failsafe states exactly
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    disarmed_q == ((mode_q == MODE_ACTIVE) || (mode_q == MODE_RECOVERING)))
    else $error("disarm flag out of step with link state");

  // recovering is only reached from active or recovering
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && (mode_d == MODE_RECOVERING) |->
      (mode_q == MODE_ACTIVE) || (mode_q == MODE_RECOVERING))
    else $error("recovering entered from wrong state");

  // state holds between items
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> $stable(mode_q) && $stable(last_frame_q) && $stable(disarmed_q))
    else $error("state changed without an item");

  // a reset item always lands in ok with disarm clear
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && (item_i.op == OpReset) |=> (mode_q == MODE_OK) && !disarmed_q)
    else $error("reset item did not clear the failsafe");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/link_loss_failsafe_fsm.sv =====
// top level of the radio link loss failsafe: input register, state machine,
// result register and configuration port; depends on llf_pkg, llf_cfg, llf_core
//
//   port group | direction | handshake                 | payload
//   in         | in        | in_valid_i / in_ready_o   | op_i, now_ms_i, frame_seen_i
//   out        | out       | out_valid_o / out_ready_i | link_state_o, disarm_o
//   cfg        | in        | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// one item per cycle sustained unless the result side stalls; each item goes
// via the input register, then the result register around the state machine.
// reset returns the state machine to ok and the registers to their defaults.
// a stalled result holds the input register; in_ready_o drops only when both
// the input register and the result register are full.
// the configuration port is always ready and takes effect on the next item.
`default_nettype none

module link_loss_failsafe_fsm (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic                        op_i,
  input  wire logic [llf_pkg::TimeW-1:0]   now_ms_i,
  input  wire logic                        frame_seen_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [1:0]                       link_state_o,
  output logic                             disarm_o,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [llf_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [llf_pkg::CfgW-1:0]    cfg_data_i
);
  import llf_pkg::*;

  cfg_t  cfg;
  item_t in_item_q;
  logic  in_valid_q;
  logic  out_valid_q;
  mode_e out_state_q;
  logic  out_disarm_q;
  mode_e core_state;
  logic  core_disarm;
  logic  advance;
  logic  in_take;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  llf_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  // handshake: an item moves into the result register when it has room
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign in_take    = in_valid_i && in_ready_o;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_item_q.op         <= op_i;
      in_item_q.now_ms     <= now_ms_i;
      in_item_q.frame_seen <= frame_seen_i;
    end
  end

  // failsafe state machine
  llf_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (advance),
    .item_i       (in_item_q),
    .cfg_i        (cfg),
    .link_state_o (core_state),
    .disarm_o     (core_disarm)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_state_q  <= core_state;
      out_disarm_q <= core_disarm;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign link_state_o = out_state_q;
  assign disarm_o     = out_disarm_q;

`ifndef SYNTHESIS
  // a held item is never dropped while the result side stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(in_item_q))
    else $error("pending item lost during stall");

  // a stalled result is not overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |-> !advance)
    else $error("result overwritten while stalled");

  // every moved item shows up as a result in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("moved item produced no result");
`endif

endmodule

`default_nettype wire
